/* rtl/hrhp_pkg.sv */
// Shared constants, codes and character helpers for the HTTP request head parser.
package hrhp_pkg;

  // Result event codes.
  localparam logic [1:0] EV_REQ_LINE = 2'd0;
  localparam logic [1:0] EV_HEADER   = 2'd1;
  localparam logic [1:0] EV_HDR_END  = 2'd2;
  localparam logic [1:0] EV_ERROR    = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_BAD_LINE   = 3'd0;
  localparam logic [2:0] ERR_BAD_METHOD = 3'd1;
  localparam logic [2:0] ERR_BAD_VER    = 3'd2;
  localparam logic [2:0] ERR_BAD_HDR    = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd4;

  // Characters of interest.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int NumMethods = 9;

  // Method name lengths, GET POST PUT PATCH DELETE HEAD OPTIONS CONNECT TRACE.
  localparam logic [2:0] METHOD_LEN [NumMethods] = '{
    3'd3, 3'd4, 3'd3, 3'd5, 3'd6, 3'd4, 3'd7, 3'd7, 3'd5
  };

  // Method names, first character in the top byte, zero padded.
  localparam logic [55:0] METHOD_NAME [NumMethods] = '{
    {"GET",     32'h0},
    {"POST",    24'h0},
    {"PUT",     32'h0},
    {"PATCH",   16'h0},
    {"DELETE",   8'h0},
    {"HEAD",    24'h0},
    "OPTIONS",
    "CONNECT",
    {"TRACE",   16'h0}
  };

  // Protocol prefix, first character in the top byte.
  localparam logic [39:0] PROTO_PREFIX = "HTTP/";

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  // Character idx of method k.
  function automatic logic [7:0] method_ch(input int k, input logic [2:0] idx);
    logic [55:0] nm;
    nm = METHOD_NAME[k];
    return nm[8'(55 - 8 * int'(idx)) -: 8];
  endfunction

  // Character idx of the protocol prefix, idx below five.
  function automatic logic [7:0] proto_ch(input logic [2:0] idx);
    return PROTO_PREFIX[8'(39 - 8 * int'(idx)) -: 8];
  endfunction

  // Decimal accumulate with saturation at 255.
  function automatic logic [7:0] sat_acc(input logic [7:0] acc, input logic [7:0] c);
    logic [11:0] v;
    v = 12'(acc) * 12'd10 + 12'(c - CH_ZERO);
    return (v > 12'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage

/* rtl/http_request_head_parser_top.sv */
// Top level of the HTTP request head parser: byte intake, line parsing, result register.
//
// Usage: request bytes enter one per transfer on the in_ stream (in_tdata is
// the byte). Lines end in CR LF; a CR is held until the next byte. For each
// line end the block emits one result on the out_ stream: request line done
// (method, version, URI span), header done (name and trimmed value spans),
// or headers end (body start offset). Errors and offset overflow emit one
// error result and then all bytes are consumed with no result until reset.
// After headers end, body bytes are consumed and dropped.
// A result is in the output register in the cycle after the byte that closes
// the line is transferred. Bytes are taken one per cycle while no result waits
// on a stalled receiver; all per-byte work is one pass of compare and counter
// logic between the state registers and the output register.
// Reset (rst_n low, synchronous) returns to the request line phase with all
// offsets at zero. When the receiver stalls with a result held, in_tready
// stays low until that result is transferred, whether or not the next byte
// would cause a result.
module http_request_head_parser_top #(
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] event_res, [5:2] method_code, [13:6] version_major,
  // [21:14] version_minor, [24:22] error_code, [40:25] first_pos,
  // [56:41] first_len, [72:57] second_pos, [88:73] second_len, rest zero
  output logic [95:0] out_tdata
);

  typedef enum logic [1:0] {
    PH_REQ  = 2'd0,
    PH_HDR  = 2'd1,
    PH_DONE = 2'd2,
    PH_HALT = 2'd3
  } phase_t;

  typedef logic [POS_BITS-1:0] pos_t;

  // Per-line parsing context.
  typedef struct packed {
    logic [2:0] tok;
    logic [8:0] cand;
    logic [2:0] midx;
    pos_t       uri_b;
    pos_t       uri_l;
    logic [2:0] vstep;
    logic [7:0] maj;
    logic [7:0] mnr;
    pos_t       name_l;
    pos_t       val_b;
    pos_t       val_nb;
  } ctx_t;

  localparam pos_t POS_MAX = '1;
  localparam pos_t POS_ONE = pos_t'(1);
  // Context after reset: every method still a candidate, all else zero.
  localparam ctx_t CTX_RST = '{cand: '1, default: '0};

  phase_t phase_r, phase_nxt;
  pos_t   offset_r, offset_nxt;
  logic   pcr_r, pcr_nxt;
  pos_t   lbeg_r, lbeg_nxt;
  ctx_t   ctx_r, ctx_nxt;
  logic   out_valid_r;
  logic [95:0] out_data_r;
  logic [95:0] res_data;
  logic   res_valid;
  logic   in_xfer;

  function automatic logic [15:0] lo16(input pos_t v);
    logic [POS_BITS+15:0] t;
    t = {16'h0, v};
    return t[15:0];
  endfunction

  function automatic ctx_t method_char(input ctx_t s, input logic [7:0] c);
    ctx_t r;
    r = s;
    for (int k = 0; k < hrhp_pkg::NumMethods; k++) begin
      if ((s.midx >= hrhp_pkg::METHOD_LEN[k]) || (hrhp_pkg::method_ch(k, s.midx) != c))
        r.cand[k] = 1'b0;
    end
    if (s.midx < 3'd7) r.midx = s.midx + 3'd1;
    return r;
  endfunction

  function automatic ctx_t method_finish(input ctx_t s);
    ctx_t r;
    r = s;
    for (int k = 0; k < hrhp_pkg::NumMethods; k++) begin
      if (hrhp_pkg::METHOD_LEN[k] != s.midx) r.cand[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic ctx_t version_char(input ctx_t s, input logic [7:0] c);
    ctx_t r;
    r = s;
    if (s.vstep < 3'd5) begin
      if (c == hrhp_pkg::proto_ch(s.vstep)) r.vstep = s.vstep + 3'd1;
      else r.tok = 3'd7;
    end else if (s.vstep == 3'd5) begin
      if (hrhp_pkg::is_digit(c)) begin
        r.maj = c - hrhp_pkg::CH_ZERO;
        r.vstep = 3'd6;
      end else r.tok = 3'd7;
    end else if (s.vstep == 3'd6) begin
      if (hrhp_pkg::is_digit(c)) r.maj = hrhp_pkg::sat_acc(s.maj, c);
      else if (c == hrhp_pkg::CH_DOT) r.vstep = 3'd7;
      else r.tok = 3'd7;
    end else begin
      if (hrhp_pkg::is_digit(c)) begin
        r.mnr = c - hrhp_pkg::CH_ZERO;
        r.tok = 3'd6;
        r.vstep = 3'd0;
      end else r.tok = 3'd7;
    end
    return r;
  endfunction

  // One byte of line content, request line or header line.
  function automatic ctx_t content(input ctx_t s, input logic hdr, input logic [7:0] c,
                                   input pos_t pos);
    ctx_t r;
    logic sp, colon, blank;
    r = s;
    sp = (c == hrhp_pkg::CH_SP);
    colon = (c == hrhp_pkg::CH_COLON);
    blank = hrhp_pkg::is_blank(c);
    if (!hdr) begin
      case (s.tok)
        3'd0: if (!sp) begin
          r = method_char(s, c);
          r.tok = 3'd1;
        end
        3'd1: begin
          if (sp) begin
            r = method_finish(s);
            r.tok = 3'd2;
          end else r = method_char(s, c);
        end
        3'd2: if (!sp) begin
          r.uri_b = pos;
          r.uri_l = POS_ONE;
          r.tok = 3'd3;
        end
        3'd3: begin
          if (sp) r.tok = 3'd4;
          else r.uri_l = s.uri_l + POS_ONE;
        end
        3'd4: if (!sp) begin
          r.tok = 3'd5;
          r.vstep = 3'd0;
          r = version_char(r, c);
        end
        3'd5: r = version_char(s, c);
        3'd6: if (s.vstep == 3'd0) begin
          if (hrhp_pkg::is_digit(c)) r.mnr = hrhp_pkg::sat_acc(s.mnr, c);
          else r.vstep = 3'd1;
        end
        default: ;
      endcase
    end else begin
      case (s.tok)
        3'd0: begin
          if (colon) r.tok = 3'd1;
          else r.name_l = s.name_l + POS_ONE;
        end
        3'd1: if (!colon) begin
          if (blank) begin
            r.tok = 3'd2;
            r.val_b = pos + POS_ONE;
          end else begin
            r.tok = 3'd3;
            r.val_b = pos;
            r.val_nb = pos;
          end
        end
        3'd2: begin
          if (colon) r.tok = 3'd4;
          else if (blank) r.val_b = pos + POS_ONE;
          else begin
            r.tok = 3'd3;
            r.val_b = pos;
            r.val_nb = pos;
          end
        end
        3'd3: begin
          if (colon) r.tok = 3'd4;
          else if (!blank) r.val_nb = pos;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Pack one result.
  function automatic logic [95:0] pack_res(
      input logic [1:0] ev, input logic [3:0] mc, input logic [7:0] mj, input logic [7:0] mn,
      input logic [2:0] ec, input logic [15:0] fp, input logic [15:0] fl,
      input logic [15:0] sp, input logic [15:0] sl);
    return {7'h0, sl, sp, fl, fp, ec, mn, mj, mc, ev};
  endfunction

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Per-byte next state and result.
  always_comb begin
    ctx_t  c1, fin;
    pos_t  pos, vlen;
    logic  hdr;
    logic [3:0] code;
    phase_nxt  = phase_r;
    offset_nxt = offset_r;
    pcr_nxt    = pcr_r;
    lbeg_nxt   = lbeg_r;
    ctx_nxt    = ctx_r;
    res_valid  = 1'b0;
    res_data   = '0;
    c1   = ctx_r;
    fin  = ctx_r;
    pos  = offset_r;
    hdr  = (phase_r == PH_HDR);
    code = '0;
    vlen = '0;
    if (phase_r == PH_REQ || phase_r == PH_HDR) begin
      if (offset_r == POS_MAX) begin
        res_valid = 1'b1;
        res_data  = pack_res(hrhp_pkg::EV_ERROR, 4'd0, 8'd0, 8'd0, hrhp_pkg::ERR_TOO_LONG,
                             16'd0, 16'd0, 16'd0, 16'd0);
        phase_nxt = PH_HALT;
      end else begin
        offset_nxt = offset_r + POS_ONE;
        if (pcr_r && in_tdata == hrhp_pkg::CH_LF) begin
          // Line end.
          pcr_nxt = 1'b0;
          res_valid = 1'b1;
          fin = (ctx_r.tok == 3'd1) ? method_finish(ctx_r) : ctx_r;
          for (int k = hrhp_pkg::NumMethods - 1; k >= 0; k--) begin
            if (fin.cand[k]) code = 4'(k);
          end
          if (ctx_r.val_nb >= ctx_r.val_b) vlen = ctx_r.val_nb - ctx_r.val_b + POS_ONE;
          lbeg_nxt = pos + POS_ONE;
          ctx_nxt.tok = 3'd0;
          ctx_nxt.vstep = 3'd0;
          ctx_nxt.name_l = '0;
          ctx_nxt.val_b = '0;
          ctx_nxt.val_nb = '0;
          ctx_nxt.cand = fin.cand;
          if (!hdr) begin
            if (ctx_r.tok == 3'd0) begin
              res_data = pack_res(hrhp_pkg::EV_ERROR, 4'd0, 8'd0, 8'd0,
                                  hrhp_pkg::ERR_BAD_LINE, 16'd0, 16'd0, 16'd0, 16'd0);
              phase_nxt = PH_HALT;
            end else if (fin.cand == '0) begin
              res_data = pack_res(hrhp_pkg::EV_ERROR, 4'd0, 8'd0, 8'd0,
                                  hrhp_pkg::ERR_BAD_METHOD, 16'd0, 16'd0, 16'd0, 16'd0);
              phase_nxt = PH_HALT;
            end else if (ctx_r.tok <= 3'd4) begin
              res_data = pack_res(hrhp_pkg::EV_ERROR, 4'd0, 8'd0, 8'd0,
                                  hrhp_pkg::ERR_BAD_LINE, 16'd0, 16'd0, 16'd0, 16'd0);
              phase_nxt = PH_HALT;
            end else if (ctx_r.tok != 3'd6) begin
              res_data = pack_res(hrhp_pkg::EV_ERROR, 4'd0, 8'd0, 8'd0,
                                  hrhp_pkg::ERR_BAD_VER, 16'd0, 16'd0, 16'd0, 16'd0);
              phase_nxt = PH_HALT;
            end else begin
              res_data = pack_res(hrhp_pkg::EV_REQ_LINE, code, ctx_r.maj, ctx_r.mnr, 3'd0,
                                  lo16(ctx_r.uri_b), lo16(ctx_r.uri_l), 16'd0, 16'd0);
              phase_nxt = PH_HDR;
            end
          end else if (pos - POS_ONE == lbeg_r) begin
            res_data = pack_res(hrhp_pkg::EV_HDR_END, 4'd0, 8'd0, 8'd0, 3'd0,
                                lo16(pos + POS_ONE), 16'd0, 16'd0, 16'd0);
            phase_nxt = PH_DONE;
          end else if (ctx_r.tok <= 3'd1) begin
            res_data = pack_res(hrhp_pkg::EV_ERROR, 4'd0, 8'd0, 8'd0,
                                hrhp_pkg::ERR_BAD_HDR, 16'd0, 16'd0, 16'd0, 16'd0);
            phase_nxt = PH_HALT;
          end else begin
            res_data = pack_res(hrhp_pkg::EV_HEADER, 4'd0, 8'd0, 8'd0, 3'd0,
                                lo16(lbeg_r), lo16(ctx_r.name_l), lo16(ctx_r.val_b),
                                lo16(vlen));
          end
        end else begin
          // Held CR turns into content, then the new byte.
          if (pcr_r) c1 = content(ctx_r, hdr, hrhp_pkg::CH_CR, pos - POS_ONE);
          pcr_nxt = (in_tdata == hrhp_pkg::CH_CR);
          ctx_nxt = pcr_nxt ? c1 : content(c1, hdr, in_tdata, pos);
        end
      end
    end
  end

  // State, phase and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_REQ;
      offset_r    <= '0;
      pcr_r       <= 1'b0;
      lbeg_r      <= '0;
      ctx_r       <= CTX_RST;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (in_xfer) begin
        phase_r  <= phase_nxt;
        offset_r <= offset_nxt;
        pcr_r    <= pcr_nxt;
        lbeg_r   <= lbeg_nxt;
        ctx_r    <= ctx_nxt;
      end
      if (in_xfer && res_valid) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (in_xfer && res_valid) out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An error result leaves the block halted.
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[1:0] == hrhp_pkg::EV_ERROR) |-> (phase_r == PH_HALT))
    else $error("error result without halt");

  // Halted stays halted.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT) |=> (phase_r == PH_HALT))
    else $error("left halt without reset");

  // No result is produced once done or halted.
  a_no_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (phase_r == PH_DONE || phase_r == PH_HALT)) |-> !res_valid)
    else $error("result after parsing ended");

endmodule

/* tb/http_request_head_parser_top_tb.sv */
// Self-checking testbench for the HTTP request head parser: a byte stream checked against a predictor.
module http_request_head_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One parser event, packed as on out_tdata with the event code in the lowest bits.
  typedef struct packed {
    logic [15:0] slen;
    logic [15:0] spos;
    logic [15:0] flen;
    logic [15:0] fpos;
    logic [2:0]  err;
    logic [7:0]  vmin;
    logic [7:0]  vmaj;
    logic [3:0]  meth;
    logic [1:0]  ev;
  } parse_event_t;

  typedef enum logic [1:0] {PH_REQ, PH_HDR, PH_DONE, PH_HALT} parse_phase_e;

  typedef struct {
    string        text;
    bit           typed;
    parse_event_t want;
  } line_row_t;

  localparam string METHODS [9] = '{"GET", "POST", "PUT", "PATCH", "DELETE", "HEAD",
                                   "OPTIONS", "CONNECT", "TRACE"};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  http_request_head_parser_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Request bytes in order and the parser events they should cause.
  logic [7:0]   byte_stream [$];
  parse_event_t expected_events [$];
  int           n_offered = 0;
  int           n_accepted = 0;
  int           mismatches = 0;
  int           cyc = 0;
  logic         hold_off = 1'b0;

  // Predictor state.
  parse_phase_e ph;
  logic [15:0]  ofs, line_start, uri_pos, uri_len, nlen, vbeg, vlast;
  logic         cr_held;
  int           tok, vstep, mci;
  logic [8:0]   cand;
  logic [7:0]   maj, minr;

  function automatic logic [7:0] dec_sat(input logic [7:0] acc, input logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c) - 48;
    return (v > 255) ? 8'hFF : 8'(v);
  endfunction

  function automatic bit digit(input logic [7:0] c);
    return c >= hrhp_pkg::CH_ZERO && c <= hrhp_pkg::CH_NINE;
  endfunction

  function automatic bit blank(input logic [7:0] c);
    return c == hrhp_pkg::CH_SP || c == hrhp_pkg::CH_TAB;
  endfunction

  // Drop every method whose name does not have this character at this index.
  function automatic void method_byte(input logic [7:0] c);
    for (int k = 0; k < 9; k++) begin
      if (mci >= METHODS[k].len() || METHODS[k][mci] != c) cand[k] = 1'b0;
    end
    if (mci < 7) mci++;
  endfunction

  function automatic void method_close();
    for (int k = 0; k < 9; k++) begin
      if (METHODS[k].len() != mci) cand[k] = 1'b0;
    end
  endfunction

  // Walk through "HTTP/", the major digits, the dot and the first minor digit.
  function automatic void version_byte(input logic [7:0] c);
    if (vstep < 5) begin
      if (c == hrhp_pkg::proto_ch(3'(vstep))) vstep++;
      else tok = 7;
    end else if (vstep == 5) begin
      if (digit(c)) begin
        maj = c - hrhp_pkg::CH_ZERO;
        vstep = 6;
      end else tok = 7;
    end else if (vstep == 6) begin
      if (digit(c)) maj = dec_sat(maj, c);
      else if (c == hrhp_pkg::CH_DOT) vstep = 7;
      else tok = 7;
    end else begin
      if (digit(c)) begin
        minr = c - hrhp_pkg::CH_ZERO;
        tok = 6;
        vstep = 0;
      end else tok = 7;
    end
  endfunction

  function automatic void request_byte(input logic [7:0] c, input logic [15:0] pos);
    bit sp;
    sp = (c == hrhp_pkg::CH_SP);
    case (tok)
      0: if (!sp) begin
        tok = 1;
        method_byte(c);
      end
      1: if (sp) begin
        method_close();
        tok = 2;
      end else method_byte(c);
      2: if (!sp) begin
        uri_pos = pos;
        uri_len = 16'd1;
        tok = 3;
      end
      3: if (sp) tok = 4;
      else uri_len++;
      4: if (!sp) begin
        tok = 5;
        vstep = 0;
        version_byte(c);
      end
      5: version_byte(c);
      6: if (vstep == 0) begin
        if (digit(c)) minr = dec_sat(minr, c);
        else vstep = 1;
      end
      default: ;
    endcase
  endfunction

  function automatic void header_byte(input logic [7:0] c, input logic [15:0] pos);
    bit colon;
    colon = (c == hrhp_pkg::CH_COLON);
    case (tok)
      0: if (colon) tok = 1;
      else nlen++;
      1: if (!colon) begin
        if (blank(c)) begin
          tok = 2;
          vbeg = pos + 16'd1;
        end else begin
          tok = 3;
          vbeg = pos;
          vlast = pos;
        end
      end
      2: if (colon) tok = 4;
      else if (blank(c)) vbeg = pos + 16'd1;
      else begin
        tok = 3;
        vbeg = pos;
        vlast = pos;
      end
      3: if (colon) tok = 4;
      else if (!blank(c)) vlast = pos;
      default: ;
    endcase
  endfunction

  function automatic parse_event_t halt_with(input logic [2:0] code);
    parse_event_t r;
    r = '0;
    r.ev = hrhp_pkg::EV_ERROR;
    r.err = code;
    ph = PH_HALT;
    return r;
  endfunction

  // Event for the line that the LF at pos closes.
  function automatic parse_event_t line_close(input logic [15:0] pos);
    parse_event_t r;
    int code;
    r = '0;
    code = 0;
    if (ph == PH_REQ) begin
      if (tok == 1) method_close();
      if (tok == 0) return halt_with(hrhp_pkg::ERR_BAD_LINE);
      if (cand == '0) return halt_with(hrhp_pkg::ERR_BAD_METHOD);
      if (tok <= 4) return halt_with(hrhp_pkg::ERR_BAD_LINE);
      if (tok != 6) return halt_with(hrhp_pkg::ERR_BAD_VER);
      for (int k = 8; k >= 0; k--) if (cand[k]) code = k;
      r.ev = hrhp_pkg::EV_REQ_LINE;
      r.meth = 4'(code);
      r.vmaj = maj;
      r.vmin = minr;
      r.fpos = uri_pos;
      r.flen = uri_len;
      ph = PH_HDR;
    end else if (pos - 16'd1 == line_start) begin
      r.ev = hrhp_pkg::EV_HDR_END;
      r.fpos = pos + 16'd1;
      ph = PH_DONE;
    end else begin
      if (tok <= 1) return halt_with(hrhp_pkg::ERR_BAD_HDR);
      r.ev = hrhp_pkg::EV_HEADER;
      r.fpos = line_start;
      r.flen = nlen;
      r.spos = vbeg;
      r.slen = (vlast >= vbeg) ? vlast - vbeg + 16'd1 : 16'd0;
    end
    line_start = pos + 16'd1;
    tok = 0;
    vstep = 0;
    nlen = '0;
    vbeg = '0;
    vlast = '0;
    return r;
  endfunction

  function automatic void line_byte(input logic [7:0] c, input logic [15:0] pos);
    if (ph == PH_REQ) request_byte(c, pos);
    else header_byte(c, pos);
  endfunction

  // Advance the predictor by one byte; returns 1 when the byte causes an event.
  function automatic bit predict_byte(input logic [7:0] c, output parse_event_t r);
    logic [15:0] pos;
    r = '0;
    if (ph == PH_DONE || ph == PH_HALT) return 1'b0;
    if (ofs == 16'hFFFF) begin
      r = halt_with(hrhp_pkg::ERR_TOO_LONG);
      return 1'b1;
    end
    pos = ofs;
    ofs = pos + 16'd1;
    if (c == hrhp_pkg::CH_LF && cr_held) begin
      cr_held = 1'b0;
      r = line_close(pos);
      return 1'b1;
    end
    if (cr_held) begin
      line_byte(hrhp_pkg::CH_CR, pos - 16'd1);
      cr_held = 1'b0;
    end
    if (c == hrhp_pkg::CH_CR) cr_held = 1'b1;
    else line_byte(c, pos);
    return 1'b0;
  endfunction

  function automatic void push_byte(input logic [7:0] c);
    parse_event_t r;
    byte_stream.push_back(c);
    if (predict_byte(c, r)) expected_events.push_back(r);
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // Any byte but colon, CR, and optionally LF.
  function automatic logic [7:0] plain_byte(input bit no_lf);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == hrhp_pkg::CH_COLON || c == hrhp_pkg::CH_CR || (no_lf && c == hrhp_pkg::CH_LF));
    return c;
  endfunction

  // Content byte, now and then a CR that some other byte follows.
  function automatic void push_content(input logic [7:0] c);
    if ($urandom_range(0, 19) == 0) begin
      push_byte(hrhp_pkg::CH_CR);
      push_byte(plain_byte(1'b1));
    end
    push_byte(c);
  endfunction

  function automatic void push_digits(input int n);
    for (int i = 0; i < n; i++) push_byte(8'(hrhp_pkg::CH_ZERO + $urandom_range(0, 9)));
  endfunction

  // Random request line; now and then broken in one of the ways the parser rejects.
  function automatic void push_request_line();
    string nm;
    int    flaw;
    nm = METHODS[$urandom_range(0, 8)];
    flaw = $urandom_range(0, 19);
    if (flaw == 0) nm[$urandom_range(0, nm.len() - 1)] = 8'($urandom_range(65, 90));
    if (flaw == 1) nm = {nm, "S"};
    if (flaw == 2) begin
      push_str("\015\012");
      return;
    end
    repeat ($urandom_range(0, 1)) push_byte(hrhp_pkg::CH_SP);
    push_str(nm);
    repeat ($urandom_range(1, 3)) push_byte(hrhp_pkg::CH_SP);
    repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(33, 126)));
    if (flaw != 3) begin
      repeat ($urandom_range(1, 3)) push_byte(hrhp_pkg::CH_SP);
      push_str(flaw == 4 ? "HTTP-" : "HTTP/");
      push_digits(flaw == 5 ? 0 : $urandom_range(1, 4));
      push_byte(flaw == 6 ? 8'h2C : hrhp_pkg::CH_DOT);
      push_digits(flaw == 7 ? 0 : $urandom_range(1, 4));
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3))
        push_byte(8'($urandom_range(32, 126)));
    end
    push_str("\015\012");
  endfunction

  // Random well-formed header line with random name and value content.
  function automatic void push_header_line();
    repeat ($urandom_range(0, 6)) push_content(plain_byte(1'b0));
    push_byte(hrhp_pkg::CH_COLON);
    repeat ($urandom_range(0, 1)) push_byte(hrhp_pkg::CH_COLON);
    repeat ($urandom_range(0, 3))
      push_byte($urandom_range(0, 1) ? hrhp_pkg::CH_SP : hrhp_pkg::CH_TAB);
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 3) == 0)
        push_byte($urandom_range(0, 1) ? hrhp_pkg::CH_SP : hrhp_pkg::CH_TAB);
      else push_content(plain_byte(1'b0));
    end
    if ($urandom_range(0, 4) == 0) begin
      push_byte(hrhp_pkg::CH_COLON);
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)) | 8'h80);
    end
    push_str("\015\012");
  endfunction

  // Whole request stream: directed lines, random headers, then one way of ending.
  function automatic void build_stream();
    line_row_t    rows [];
    parse_event_t row_want, r;
    bit           random_start;
    ph = PH_REQ;
    ofs = '0;
    cr_held = 1'b0;
    line_start = '0;
    tok = 0;
    cand = '1;
    mci = 0;
    uri_pos = '0;
    uri_len = '0;
    vstep = 0;
    maj = '0;
    minr = '0;
    nlen = '0;
    vbeg = '0;
    vlast = '0;
    row_want = '0;
    row_want.ev = hrhp_pkg::EV_REQ_LINE;
    row_want.vmaj = 8'd1;
    row_want.vmin = 8'd1;
    row_want.fpos = 16'd4;
    row_want.flen = 16'd6;
    rows = '{
      '{"GET /index HTTP/1.1\015\012", 1'b1, row_want},
      '{"Host: a\015\012", 1'b0, '0},
      '{":\011v\011\015\012", 1'b0, '0},
      '{"K:: x y :z\015\012", 1'b0, '0},
      '{"B:   \015\012", 1'b0, '0},
      '{"C: a\015b\012c \015\012", 1'b0, '0},
      '{"\177\001~:\377\200\015\012", 1'b0, '0}
    };
    random_start = ($urandom_range(0, 2) == 0);
    if (random_start) push_request_line();
    foreach (rows[i]) begin
      if (i == 0 && random_start) continue;
      for (int j = 0; j < rows[i].text.len(); j++) begin
        byte_stream.push_back(rows[i].text[j]);
        if (predict_byte(rows[i].text[j], r))
          expected_events.push_back(rows[i].typed ? rows[i].want : r);
      end
    end
    while (byte_stream.size() < 1500 && ph == PH_HDR) push_header_line();
    case ($urandom_range(0, 4))
      0: push_str("X-none\015\012");
      1: push_str("Q:::\015\012");
      default: push_str("\015\012");
    endcase
    repeat (20) push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic string show(input parse_event_t e);
    return $sformatf("ev=%0d meth=%0d ver=%0d.%0d err=%0d first=%0d/%0d second=%0d/%0d",
                     e.ev, e.meth, e.vmaj, e.vmin, e.err, e.fpos, e.flen, e.spos, e.slen);
  endfunction

  // Compare one received event with the oldest expected one.
  task automatic check_event(input logic [95:0] data);
    parse_event_t got, want;
    bit           bad;
    got = data[88:0];
    if (expected_events.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected event: %s", show(got));
    end else begin
      want = expected_events.pop_front();
      bad = (got.ev != want.ev) || (got.meth != want.meth) || (got.vmaj != want.vmaj) ||
            (got.vmin != want.vmin) || (got.err != want.err) || (got.fpos != want.fpos) ||
            (got.flen != want.flen) || (got.spos != want.spos) || (got.slen != want.slen) ||
            (data[95:89] != '0);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) $display("event mismatch: expected %s, got %s (pad %h)",
                                       show(want), show(got), data[95:89]);
      end
    end
  endtask

  // Random gaps, with one long stretch of none.
  function automatic bit random_gap();
    return !(cyc >= 1500 && cyc < 2000) && ($urandom_range(0, 99) < 20);
  endfunction

  // Cycle count and the long receiver hold-off.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    hold_off <= (cyc >= 1000 && cyc < 1400);
  end

  // Byte sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) n_accepted++;
      if (!in_tvalid || in_tready) begin
        if (n_offered < byte_stream.size() && !random_gap()) begin
          in_tdata <= byte_stream[n_offered];
          in_tvalid <= 1'b1;
          n_offered++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Event receiver.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_event(out_tdata);
      out_tready <= !hold_off && !random_gap();
    end
  end

  initial begin
    build_stream();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (n_accepted == byte_stream.size());
    wait (expected_events.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/hrhp_pkg.sv
rtl/http_request_head_parser_top.sv
tb/http_request_head_parser_top_tb.sv
